// ----- sv/k_group_reverse_core_macros.svh -----
// ----------------------------------------------------------------------------
// k_group_reverse_core_macros.svh
// Assertion shorthands used by the port checker of the core.
// ----------------------------------------------------------------------------
`ifndef K_GROUP_REVERSE_CORE_MACROS_SVH
`define K_GROUP_REVERSE_CORE_MACROS_SVH

// Plain property, sampled on the rising clock edge and quiet during reset.
`define KGR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define KGR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define KGR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/kgr_pkg.sv -----
// ----------------------------------------------------------------------------
// kgr_pkg
// Request types and fixed widths shared by the group reversal core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kgr_pkg;

	localparam int VALUE_W = 32;
	localparam int CFG_W   = 5;

	// Reset value of the group size register.
	localparam logic [CFG_W-1:0] GROUP_SIZE_RST = 5'd2;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      is_last;
	} in_req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value_res;
		logic                      is_last_res;
	} out_req_t;

endpackage

`default_nettype wire

// ----- sv/k_group_reverse_core.sv -----
// ----------------------------------------------------------------------------
// k_group_reverse_core
// Reverses a stream of signed 32-bit values in groups of a configurable size.
// ----------------------------------------------------------------------------
// Usage: values enter one request at a time and are written into a group
// memory of MAX_GROUP entries. When the number of buffered values reaches
// the group size, the whole group is read back newest first; when a request
// carries is_last before the group is full, the buffered tail is read back
// in arrival order instead. The final result of a sequence carries
// is_last_res. Each value costs one input request and one memory read; the
// drain begins once the closing request is taken, and a read is issued
// whenever the output register is empty or being taken, so the single read
// port of the group memory sets the drain speed. While a group drains,
// in_stall is high. The read data register doubles as the output register,
// so the next input can be accepted while the last result of a group still
// waits on out_stall. The group size register is written over its own
// channel and is always ready; a size of zero acts as one and a size above
// MAX_GROUP acts as MAX_GROUP. Changing it keeps buffered values, and a
// lowered size closes the group on the next value. No clearing pass runs
// after reset: only entries written within the current group are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module k_group_reverse_core #(
	parameter int MAX_GROUP = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	// Input request channel.
	input  wire                         in_valid,
	output logic                        in_stall,
	input  kgr_pkg::in_req_t            in_data,
	// Result channel.
	output logic                        out_valid,
	input  wire                         out_stall,
	output kgr_pkg::out_req_t           out_data,
	// Group size write channel.
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire [kgr_pkg::CFG_W-1:0]    cfg_data
);

	// Count width holds 0..MAX_GROUP; address width indexes the memory.
	localparam int CW    = $clog2(MAX_GROUP + 1);
	localparam int AW    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int CMP_W = (CW > kgr_pkg::CFG_W) ? CW : kgr_pkg::CFG_W;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                         state_q;
	logic [kgr_pkg::CFG_W-1:0]    group_size_q;
	logic [CW-1:0]                fill_q;
	logic [CW-1:0]                cnt_q;
	logic [AW-1:0]                addr_q;
	logic                         down_q;
	logic                         seq_last_q;

	// Group memory and its registered read port (also the output register).
	logic [kgr_pkg::VALUE_W-1:0]  group_mem [MAX_GROUP];
	logic [kgr_pkg::VALUE_W-1:0]  rd_data_q;
	logic                         rd_last_q;
	logic                         out_valid_q;

	logic                         in_acc;
	logic                         rd_en;
	logic [CW-1:0]                fill_next;
	logic                         group_full;
	logic                         emit;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Count after this value is stored. A group closes when it reaches the
	// configured size or the memory depth; a size of zero always closes.
	assign fill_next  = fill_q + CW'(1);
	assign group_full = (CMP_W'(fill_next) >= CMP_W'(group_size_q)) ||
	                    (fill_next == CW'(MAX_GROUP));
	assign emit       = group_full || in_data.is_last;

	// A read is issued whenever the output register is empty or being taken.
	assign rd_en = (state_q == ST_DRAIN) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= kgr_pkg::GROUP_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			group_size_q <= cfg_data;
		end
	end

	// Control: fill tracking and the drain sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			cnt_q       <= '0;
			addr_q      <= '0;
			down_q      <= 1'b0;
			seq_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (emit) begin
							// A full group reads back from the newest entry down;
							// a short tail reads from the oldest entry up.
							state_q    <= ST_DRAIN;
							cnt_q      <= fill_next;
							addr_q     <= group_full ? fill_q[AW-1:0] : '0;
							down_q     <= group_full;
							seq_last_q <= in_data.is_last;
							fill_q     <= '0;
						end else begin
							fill_q <= fill_next;
						end
					end
				end
				ST_DRAIN: begin
					if (rd_en) begin
						cnt_q  <= cnt_q - CW'(1);
						addr_q <= down_q ? (addr_q - AW'(1)) : (addr_q + AW'(1));
						if (cnt_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (rd_en) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Writes happen only while idle and reads only while draining, so the
	// value stored by the closing request is visible to the first read.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			group_mem[fill_q[AW-1:0]] <= in_data.value;
		end
		if (rd_en) begin
			rd_data_q <= group_mem[addr_q];
			rd_last_q <= seq_last_q && (cnt_q == CW'(1));
		end
	end

	assign out_valid            = out_valid_q;
	assign out_data.value_res   = rd_data_q;
	assign out_data.is_last_res = rd_last_q;

endmodule

`default_nettype wire

// ----- sv/kgr_checker.sv -----
// ----------------------------------------------------------------------------
// kgr_checker
// Port-level checks for the group reversal core, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "k_group_reverse_core_macros.svh"

module kgr_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      in_valid,
	input wire                      in_stall,
	input kgr_pkg::in_req_t         in_data,
	input wire                      out_valid,
	input wire                      out_stall,
	input kgr_pkg::out_req_t        out_data,
	input wire                      cfg_valid,
	input wire                      cfg_ready,
	input wire [kgr_pkg::CFG_W-1:0] cfg_data
);

	// A stalled result stays offered and unchanged.
	`KGR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped under stall")
	`KGR_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_data), "stalled result changed")

	// The end of a sequence always flushes the buffer, so input must stall.
	`KGR_ASSERT_NXT(a_last_drains, clk, arst_n, in_valid && !in_stall && in_data.is_last, in_stall, "sequence end did not drain")

	// The group size register takes a write in every cycle.
	`KGR_ASSERT(a_cfg_ready, clk, arst_n, cfg_ready, "group size write refused")

endmodule

bind k_group_reverse_core kgr_checker u_kgr_checker (.*);

`default_nettype wire
